@@ design/dasd_pkg.sv @@
`timescale 1ns / 1ps
package dasd_pkg;

	localparam logic [7:0] CFG_MIN_PULSE = 8'd0;
	localparam logic [7:0] CFG_MAX_PULSE = 8'd1;
	localparam logic [7:0] CFG_PERIOD    = 8'd2;

	localparam logic [14:0] MIN_PULSE_RST = 15'd1000;
	localparam logic [14:0] MAX_PULSE_RST = 15'd2000;
	localparam logic [15:0] PERIOD_RST    = 16'd20000;

	localparam logic [16:0] ACC_MAX   = 17'd9999;
	localparam logic [13:0] ANGLE_MAX = 14'd180;

	// ceil(2^31 / 180), exact floor for every angle * span product
	localparam logic [23:0] RECIP_180 = 24'd11930465;

	localparam logic [7:0] CHAR_CR   = 8'd13;
	localparam logic [7:0] CHAR_LF   = 8'd10;
	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_NINE = 8'd57;

	typedef struct packed {
		logic [14:0] min_pulse;
		logic [14:0] max_pulse;
		logic [15:0] pwm_period;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [15:0] rem_init;
		logic [15:0] low;
		logic [4:0]  nbits;
		logic [15:0] divisor;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RECIP,
		ST_ADD,
		ST_DIV,
		ST_WAIT,
		ST_OUT
	} back_state_t;

endpackage

@@ design/dasd_front.sv @@
`timescale 1ns / 1ps
module dasd_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        q_full,
	output logic        push,
	output logic [13:0] push_angle
);

	logic [13:0] accum_q;
	logic        have_q;
	logic        accept;
	logic        is_digit;
	logic        is_term;
	logic [16:0] next_val;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_digit = (rx_byte >= dasd_pkg::CHAR_ZERO) && (rx_byte <= dasd_pkg::CHAR_NINE);
	assign is_term  = (rx_byte == dasd_pkg::CHAR_CR) || (rx_byte == dasd_pkg::CHAR_LF);
	assign next_val = 17'(accum_q) * 17'd10 + 17'(rx_byte - dasd_pkg::CHAR_ZERO);

	assign push       = accept && is_term && have_q;
	assign push_angle = accum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
			have_q  <= 1'b0;
		end else if (accept) begin
			if (is_term) begin
				accum_q <= '0;
				have_q  <= 1'b0;
			end else if (is_digit) begin
				accum_q <= (next_val > dasd_pkg::ACC_MAX) ? dasd_pkg::ACC_MAX[13:0] : next_val[13:0];
				have_q  <= 1'b1;
			end
		end
	end

endmodule

@@ design/dasd_fifo.sv @@
`timescale 1ns / 1ps
module dasd_fifo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [13:0] push_data,
	input  logic        pop,
	output logic        not_empty,
	output logic        full,
	output logic [13:0] pop_data
);

	logic [13:0] mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign not_empty = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ design/dasd_div.sv @@
`timescale 1ns / 1ps
module dasd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  dasd_pkg::div_req_t  req,
	output logic                busy,
	output logic [15:0]         quot
);

	logic [15:0] rem_q;
	logic [15:0] low_q;
	logic [15:0] quot_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	assign trial = {rem_q, low_q[15]};
	assign diff  = trial - {1'b0, req.divisor};
	assign ge    = (trial >= {1'b0, req.divisor});
	assign busy  = (cnt_q != 5'd0);
	assign quot  = quot_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			low_q  <= req.low;
			quot_q <= '0;
		end else if (busy) begin
			rem_q  <= ge ? diff[15:0] : trial[15:0];
			low_q  <= {low_q[14:0], 1'b0};
			quot_q <= {quot_q[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= req.nbits;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

endmodule

@@ design/dasd_back.sv @@
`timescale 1ns / 1ps
module dasd_back #(
	parameter int DUTY_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dasd_pkg::cfg_t      cfg,
	input  logic                q_not_empty,
	input  logic [13:0]         q_angle,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [13:0]         angle,
	output logic                in_range,
	output logic [14:0]         pulse_width,
	output logic [15:0]         duty_counts
);

	localparam int QB = (DUTY_BITS < 16) ? DUTY_BITS : 16;
	localparam int SH = DUTY_BITS - QB;
	localparam int RW = 15 + SH;
	localparam int CW = (RW > 16) ? RW : 16;
	localparam logic [15:0] FULL_SCALE = 16'((32'd1 << QB) - 32'd1);

	dasd_pkg::back_state_t state_q;
	dasd_pkg::back_state_t state_d;
	dasd_pkg::div_req_t    div_req;

	logic [13:0] angle_q;
	logic        in_range_q;
	logic [14:0] pulse_q;
	logic [15:0] duty_q;
	logic [22:0] prod_q;
	logic [14:0] quot_q;
	logic [46:0] recip_prod;
	logic [14:0] span;
	logic [CW-1:0] rem0;
	logic        sat;
	logic        div_busy;
	logic [15:0] div_quot;

	assign span = (cfg.max_pulse >= cfg.min_pulse) ?
		(cfg.max_pulse - cfg.min_pulse) : 15'd0;
	assign recip_prod = 47'(prod_q) * 47'(dasd_pkg::RECIP_180);
	assign rem0 = CW'(pulse_q) << SH;
	assign sat  = (rem0 >= CW'(cfg.pwm_period));

	dasd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dasd_pkg::ST_IDLE: begin
				if (q_not_empty) begin
					state_d = (q_angle > dasd_pkg::ANGLE_MAX) ? dasd_pkg::ST_OUT : dasd_pkg::ST_MUL;
				end
			end
			dasd_pkg::ST_MUL:   state_d = dasd_pkg::ST_RECIP;
			dasd_pkg::ST_RECIP: state_d = dasd_pkg::ST_ADD;
			dasd_pkg::ST_ADD:   state_d = dasd_pkg::ST_DIV;
			dasd_pkg::ST_DIV:   state_d = sat ? dasd_pkg::ST_OUT : dasd_pkg::ST_WAIT;
			dasd_pkg::ST_WAIT: begin
				if (!div_busy) begin
					state_d = dasd_pkg::ST_OUT;
				end
			end
			dasd_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = dasd_pkg::ST_IDLE;
				end
			end
			default: state_d = dasd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop            = 1'b0;
		out_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.rem_init = rem0[15:0];
		div_req.low      = '0;
		div_req.nbits    = 5'(QB);
		div_req.divisor  = cfg.pwm_period;
		case (state_q)
			dasd_pkg::ST_IDLE: q_pop = q_not_empty;
			dasd_pkg::ST_DIV:  div_req.start = !sat;
			dasd_pkg::ST_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dasd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dasd_pkg::ST_IDLE: begin
				angle_q    <= q_angle;
				in_range_q <= (q_angle <= dasd_pkg::ANGLE_MAX);
				pulse_q    <= '0;
				duty_q     <= '0;
			end
			dasd_pkg::ST_MUL:   prod_q <= 23'(angle_q[7:0]) * 23'(span);
			dasd_pkg::ST_RECIP: quot_q <= recip_prod[45:31];
			dasd_pkg::ST_ADD:   pulse_q <= cfg.min_pulse + quot_q;
			dasd_pkg::ST_DIV: begin
				if (sat) begin
					duty_q <= FULL_SCALE;
				end
			end
			dasd_pkg::ST_WAIT: begin
				if (!div_busy) begin
					duty_q <= div_quot;
				end
			end
			default: ;
		endcase
	end

	assign angle       = angle_q;
	assign in_range    = in_range_q;
	assign pulse_width = pulse_q;
	assign duty_counts = duty_q;

endmodule

@@ design/decimal_angle_to_servo_duty.sv @@
`timescale 1ns / 1ps
// decimal angle to servo duty
// in channel (in_valid/in_ready, rx_byte): one received character per word;
// digits build a decimal angle, cr or lf after a digit closes it
// out channel (out_valid/out_ready): angle, in_range, pulse_width, duty_counts
// cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 min pulse,
// 1 max pulse, 2 period; other indexes are dropped; cfg_ready is always high
// closed angles wait in a two-entry queue and the input stalls only while
// that queue is full
// an in-range angle taken from the queue passes through a multiply, a
// reciprocal multiply for the divide by 180, an add, then a bit-serial
// divide by the period to min(DUTY_BITS,16) bits; a saturated duty skips
// the divide and an out-of-range angle goes straight to the outputs
// the back works on one angle at a time and takes no new angle from the
// queue until the last result has been taken
// result stays on the outputs until out_ready; the back stalls meanwhile
// while the front keeps taking bytes until the queue is full
// reset clears the accumulator and queue, returns the back to idle, and loads
// the default pulse range 1000..2000 us and period 20000 us
module decimal_angle_to_servo_duty #(
	parameter int DUTY_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [13:0] angle,
	output logic        in_range,
	output logic [14:0] pulse_width,
	output logic [15:0] duty_counts,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	dasd_pkg::cfg_t cfg_q;

	logic        push;
	logic [13:0] push_angle;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;
	logic [13:0] q_angle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse  <= dasd_pkg::MIN_PULSE_RST;
			cfg_q.max_pulse  <= dasd_pkg::MAX_PULSE_RST;
			cfg_q.pwm_period <= dasd_pkg::PERIOD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				dasd_pkg::CFG_MIN_PULSE: cfg_q.min_pulse  <= cfg_data[14:0];
				dasd_pkg::CFG_MAX_PULSE: cfg_q.max_pulse  <= cfg_data[14:0];
				dasd_pkg::CFG_PERIOD:    cfg_q.pwm_period <= cfg_data;
				default: ;
			endcase
		end
	end

	dasd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_angle (push_angle)
	);

	dasd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_angle),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.pop_data  (q_angle)
	);

	dasd_back #(
		.DUTY_BITS (DUTY_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_angle     (q_angle),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.angle       (angle),
		.in_range    (in_range),
		.pulse_width (pulse_width),
		.duty_counts (duty_counts)
	);

endmodule

@@ verif/tb_decimal_angle_to_servo_duty.sv @@
`timescale 1ns / 1ps
module tb_decimal_angle_to_servo_duty;

	localparam int DUTY_W = 16;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 70;
	localparam int PRESSURE_PHASE = 2;
	localparam int PRESSURE_LINES = 30;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam logic [7:0] FIRST_UNUSED_REG = dasd_pkg::CFG_PERIOD + 8'd1;

	typedef struct packed {
		logic [13:0] angle;
		logic        in_range;
		logic [14:0] pulse;
		logic [15:0] duty;
	} servo_result_t;

	class servo_scoreboard;
		logic [14:0] min_us;
		logic [14:0] max_us;
		logic [15:0] period;
		logic [13:0] accum;
		bit          have_digit;
		servo_result_t pending_results[$];
		int errors;
		int checked;
		int out_of_range;

		function new();
			min_us = dasd_pkg::MIN_PULSE_RST;
			max_us = dasd_pkg::MAX_PULSE_RST;
			period = dasd_pkg::PERIOD_RST;
			accum = '0;
			have_digit = 1'b0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [15:0] data);
			case (idx)
				dasd_pkg::CFG_MIN_PULSE: min_us = data[14:0];
				dasd_pkg::CFG_MAX_PULSE: max_us = data[14:0];
				dasd_pkg::CFG_PERIOD:    period = data;
				default: ;
			endcase
		endfunction

		function logic [14:0] pulse_for_angle(logic [13:0] deg);
			int unsigned span;
			int unsigned sum;
			span = 0;
			if (max_us >= min_us)
				span = max_us - min_us;
			sum = min_us + (deg * span) / dasd_pkg::ANGLE_MAX;
			return 15'(sum);
		endfunction

		function logic [15:0] duty_for_pulse(logic [14:0] p);
			longint unsigned full;
			longint unsigned q;
			full = (64'd1 << DUTY_W) - 1;
			if (full > 64'hFFFF)
				full = 64'hFFFF;
			if (period == 16'd0)
				return 16'(full);
			q = (64'(p) << DUTY_W) / period;
			if (q > full)
				q = full;
			return 16'(q);
		endfunction

		// returns 1 for a digit or for a terminator that closes a line
		function bit note_byte(logic [7:0] b);
			int unsigned v;
			servo_result_t e;
			if (b == dasd_pkg::CHAR_CR || b == dasd_pkg::CHAR_LF) begin
				if (!have_digit)
					return 1'b0;
				e.angle = accum;
				e.in_range = (accum <= dasd_pkg::ANGLE_MAX);
				e.pulse = '0;
				e.duty = '0;
				if (e.in_range) begin
					e.pulse = pulse_for_angle(accum);
					e.duty = duty_for_pulse(e.pulse);
				end else begin
					out_of_range++;
				end
				pending_results.push_back(e);
				accum = '0;
				have_digit = 1'b0;
				return 1'b1;
			end
			if (b >= dasd_pkg::CHAR_ZERO && b <= dasd_pkg::CHAR_NINE) begin
				v = accum * 10 + (b - dasd_pkg::CHAR_ZERO);
				if (v > dasd_pkg::ACC_MAX)
					v = dasd_pkg::ACC_MAX;
				accum = 14'(v);
				have_digit = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [13:0] a, logic r, logic [14:0] p, logic [15:0] d);
			servo_result_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected, actual angle %0d in_range %0d",
					$time, a, r);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			checked++;
			compare_field("angle", 16'(e.angle), 16'(a));
			compare_field("in_range", 16'(e.in_range), 16'(r));
			compare_field("pulse_width", 16'(e.pulse), 16'(p));
			compare_field("duty_counts", e.duty, d);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [13:0] angle;
	logic        in_range;
	logic [14:0] pulse_width;
	logic [15:0] duty_counts;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 8'd0;
	logic [15:0] cfg_data = 16'd0;

	servo_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	logic hold_req = 1'b0;
	int sig_bytes = 0;
	int noise_bytes = 0;
	int settings = 1;
	int stall_cycles = 0;
	int tx_idle_by_mode[4] = '{0, 71, 0, 26};
	int rx_stall_by_mode[4] = '{0, 0, 71, 26};

	decimal_angle_to_servo_duty #(.DUTY_BITS(DUTY_W)) dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		int hold_count;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
					@(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk)
		if (out_valid && out_ready)
			sb.check_result(angle, in_range, pulse_width, duty_counts);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", stall_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (sb.note_byte(b))
			sig_bytes++;
		else
			noise_bytes++;
	endtask

	task automatic send_value(input int v, input int zeros, input logic [7:0] term);
		logic [7:0] digs[$];
		int x;
		x = v;
		do begin
			digs.push_front(dasd_pkg::CHAR_ZERO + 8'(x % 10));
			x = x / 10;
		end while (x > 0);
		repeat (zeros) digs.push_front(dasd_pkg::CHAR_ZERO);
		foreach (digs[i])
			send_byte(digs[i]);
		send_byte(term);
	endtask

	task automatic send_random_sequence();
		int kind;
		int pick;
		int v;
		logic [7:0] term;
		kind = $urandom_range(99);
		term = $urandom_range(1) ? dasd_pkg::CHAR_CR : dasd_pkg::CHAR_LF;
		if (kind < 72) begin
			pick = $urandom_range(99);
			if (pick < 70)
				v = $urandom_range(180);
			else if (pick < 76)
				v = pick[0] ? 180 : 181;
			else if (pick < 92)
				v = $urandom_range(9999, 182);
			else
				v = $urandom_range(99999999, 10000);
			if ($urandom_range(19) == 0)
				send_byte(8'($urandom));
			send_value(v, ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0, term);
		end else if (kind < 80) begin
			send_byte(term);
		end else if (kind < 90) begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
		end else begin
			// digits left open, the next line picks them up
			repeat ($urandom_range(3, 1))
				send_byte(dasd_pkg::CHAR_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic set_config(input logic [15:0] mn, input logic [15:0] mx,
		input logic [15:0] per);
		logic [7:0] idx[4];
		logic [15:0] val[4];
		idx = '{dasd_pkg::CFG_MIN_PULSE, dasd_pkg::CFG_MAX_PULSE, dasd_pkg::CFG_PERIOD,
			8'($urandom_range(255, FIRST_UNUSED_REG))};
		val = '{mn, mx, per, 16'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [15:0] min_tab[N_PHASES];
		logic [15:0] max_tab[N_PHASES];
		logic [15:0] per_tab[N_PHASES];
		int start;
		min_tab = '{16'd1000, 16'd0, 16'd20000, 16'hFFFF, 16'd500, 16'd0, 16'd0, 16'd0};
		max_tab = '{16'd2000, 16'd20000, 16'd0, 16'hFFFF, 16'd2500, 16'd0, 16'd0, 16'd0};
		per_tab = '{16'd20000, 16'd1, 16'd65535, 16'd0, 16'd20000, 16'd0, 16'd0, 16'd0};
		for (int i = 5; i < N_PHASES; i++) begin
			min_tab[i] = 16'($urandom_range(20000));
			max_tab[i] = 16'($urandom_range(20000));
			per_tab[i] = 16'($urandom_range(65535, 1));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_value(0, 0, dasd_pkg::CHAR_CR);
		send_value(180, 0, dasd_pkg::CHAR_LF);
		send_value(181, 0, dasd_pkg::CHAR_CR);
		send_value(99999, 0, dasd_pkg::CHAR_LF);
		send_byte(dasd_pkg::CHAR_CR);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(dasd_pkg::CHAR_ZERO - 8'd1);
		send_byte(dasd_pkg::CHAR_NINE + 8'd1);
		send_value(7, 2, dasd_pkg::CHAR_CR);
		send_value(2456, 0, dasd_pkg::CHAR_LF);
		in_valid <= 1'b0;

		for (int phase = 0; phase < N_PHASES; phase++) begin
			wait_drained();
			if (phase > 0)
				set_config(min_tab[phase], max_tab[phase], per_tab[phase]);
			tx_idle_pct = tx_idle_by_mode[phase % 4];
			rx_stall_pct = rx_stall_by_mode[phase % 4];
			if (phase == PRESSURE_PHASE) begin
				hold_req <= 1'b1;
				repeat (PRESSURE_LINES) send_value(5, 0, dasd_pkg::CHAR_CR);
			end
			start = sig_bytes;
			while (sig_bytes - start < PHASE_ITEMS)
				send_random_sequence();
			in_valid <= 1'b0;
		end
		wait_drained();

		$display("run covered %0d digit and terminator words plus %0d ignored words",
			sig_bytes, noise_bytes);
		$display("%0d results checked (%0d out of range) under %0d register settings",
			sb.checked, sb.out_of_range, settings);
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
design/dasd_pkg.sv
design/dasd_front.sv
design/dasd_fifo.sv
design/dasd_div.sv
design/dasd_back.sv
design/decimal_angle_to_servo_duty.sv
verif/tb_decimal_angle_to_servo_duty.sv
